FILE: hdl/dscl_pkg.sv
// Shared types and constants for the sorted, deduplicated cell list.
// Used by dscl_ctrl, dscl_datapath and dedup_sorted_cell_list.
package dscl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ENTRY_AW    = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_CLEAR  = 2'd1,
        REQ_READ   = 2'd2
    } req_e_t;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_CLEARED   = 3'd3,
        STAT_READ_OK   = 3'd4,
        STAT_ROW_EMPTY = 3'd5
    } status_e_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_CMP,
        ST_RESP
    } state_e_t;

    typedef struct packed {
        logic [17:0]        channel;
        logic [31:0]        hz;
        logic [8:0]         identity;
        logic [15:0]        strength;
        logic signed [15:0] margin;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      latch_req;
        logic      idx_clear;
        logic      idx_inc;
        logic      rd_idx;
        logic      rd_pos;
        logic      rd_row;
        logic      pos_load;
        logic      pos_dec;
        logic      wr_shift;
        logic      wr_new;
        logic      fill_inc;
        logic      fill_clear;
        logic      out_load;
        status_e_t out_status;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic [1:0] req_type;
        logic       dup_hit;
        logic       weaker;
        logic       scan_done;
        logic       pos_zero;
        logic       full;
        logic       row_oob;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: hdl/dscl_ctrl.sv
// Controller state machine for the sorted cell list.
// Depends on dscl_pkg; drives dscl_datapath through dp_cmd_t.
module dscl_ctrl
    import dscl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_e_t  state_reg, state_next;
    status_e_t result_reg, result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            result_reg <= STAT_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        cmd            = '0;
        cmd.out_status = result_reg;
        req_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready     = 1'b1;
                cmd.latch_req = req_valid;
                if (req_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                unique case (stat.req_type)
                    REQ_INSERT:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_SCAN_RD;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.fill_clear = 1'b1;
                        result_next    = STAT_CLEARED;
                        state_next     = ST_RESP;
                    end
                    default:
                    begin
                        // Reads, and the spare request code treated as a read.
                        if (stat.row_oob)
                        begin
                            result_next = STAT_ROW_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_row  = 1'b1;
                            result_next = STAT_READ_OK;
                        end
                        state_next = ST_RESP;
                    end
                endcase
            end

            ST_SCAN_RD:
            begin
                if (stat.scan_done)
                begin
                    if (stat.full)
                    begin
                        result_next = STAT_FULL;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        cmd.pos_load = 1'b1;
                        state_next   = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP:
            begin
                if (stat.dup_hit)
                begin
                    result_next = STAT_DUPLICATE;
                    state_next  = ST_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end

            ST_SHIFT_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.wr_new   = 1'b1;
                    cmd.fill_inc = 1'b1;
                    result_next  = STAT_INSERTED;
                    state_next   = ST_RESP;
                end
                else
                begin
                    cmd.rd_pos = 1'b1;
                    state_next = ST_SHIFT_CMP;
                end
            end

            ST_SHIFT_CMP:
            begin
                if (stat.weaker)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.pos_dec  = 1'b1;
                    state_next   = ST_SHIFT_RD;
                end
                else
                begin
                    cmd.wr_new   = 1'b1;
                    cmd.fill_inc = 1'b1;
                    result_next  = STAT_INSERTED;
                    state_next   = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/dscl_datapath.sv
// Datapath of the sorted cell list: request registers, entry memory,
// scan and insert counters, fill count and the result register. Uses dscl_pkg.
module dscl_datapath
    import dscl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [1:0]         req_type,
    input  logic [17:0]        channel_number,
    input  logic [31:0]        carrier_hz,
    input  logic [8:0]         cell_identity,
    input  logic [15:0]        strength,
    input  logic signed [15:0] margin,
    input  logic [3:0]         row,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [2:0]         status,
    output logic [4:0]         entry_count,
    output logic [3:0]         insert_row,
    output logic [17:0]        out_channel,
    output logic [31:0]        out_hz,
    output logic [8:0]         out_identity,
    output logic [15:0]        out_strength,
    output logic signed [15:0] out_margin
);

    logic [1:0]          req_type_reg;
    entry_t              new_entry_reg;
    logic [3:0]          row_reg;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    pos_m1;
    entry_t              mem [MAX_ENTRIES];
    entry_t              rd_data_reg;
    logic [ENTRY_AW-1:0] rd_addr;
    logic                rd_en;
    logic                wr_en;
    entry_t              wr_data;
    logic                rsp_valid_reg;
    status_e_t           status_reg;
    logic [4:0]          entry_count_reg;
    logic [3:0]          insert_row_reg;
    entry_t              out_entry_reg;

    assign pos_m1 = pos_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            req_type_reg           <= req_type;
            new_entry_reg.channel  <= channel_number;
            new_entry_reg.hz       <= carrier_hz;
            new_entry_reg.identity <= cell_identity;
            new_entry_reg.strength <= strength;
            new_entry_reg.margin   <= margin;
            row_reg                <= row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.pos_load)
            begin
                pos_reg <= fill_reg;
            end
            else if (cmd.pos_dec)
            begin
                pos_reg <= pos_m1;
            end

            if (cmd.fill_clear)
            begin
                fill_reg <= '0;
            end
            else if (cmd.fill_inc)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
        end
    end

    // Entry memory: one write port, one registered read port.
    always_comb
    begin
        priority if (cmd.rd_idx)
        begin
            rd_addr = idx_reg[ENTRY_AW-1:0];
        end
        else if (cmd.rd_pos)
        begin
            rd_addr = pos_m1[ENTRY_AW-1:0];
        end
        else
        begin
            rd_addr = row_reg[ENTRY_AW-1:0];
        end
    end

    assign rd_en   = cmd.rd_idx | cmd.rd_pos | cmd.rd_row;
    assign wr_en   = cmd.wr_shift | cmd.wr_new;
    assign wr_data = cmd.wr_shift ? rd_data_reg : new_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg[ENTRY_AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg      <= cmd.out_status;
            entry_count_reg <= 5'(fill_reg);
            insert_row_reg  <= (cmd.out_status == STAT_INSERTED) ? 4'(pos_reg) : 4'd0;
            out_entry_reg   <= (cmd.out_status == STAT_READ_OK) ? rd_data_reg : '0;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;
    assign insert_row   = insert_row_reg;
    assign out_channel  = out_entry_reg.channel;
    assign out_hz       = out_entry_reg.hz;
    assign out_identity = out_entry_reg.identity;
    assign out_strength = out_entry_reg.strength;
    assign out_margin   = out_entry_reg.margin;

    assign stat.req_type  = req_type_reg;
    assign stat.dup_hit   = (rd_data_reg.identity == new_entry_reg.identity);
    assign stat.weaker    = (rd_data_reg.strength < new_entry_reg.strength);
    assign stat.scan_done = (idx_reg == fill_reg);
    assign stat.pos_zero  = (pos_reg == '0);
    assign stat.full      = (fill_reg == CNT_W'(MAX_ENTRIES));
    assign stat.row_oob   = ({{(CNT_W-4){1'b0}}, row_reg} >= fill_reg);
    assign stat.out_free  = ~rsp_valid_reg | rsp_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_inc |-> (fill_reg < CNT_W'(MAX_ENTRIES)) && (pos_reg <= fill_reg))
        else $error("insert into a full list or past the last row");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (~rsp_valid_reg | rsp_ready))
        else $error("result overwritten before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_shift |=> (pos_reg == $past(pos_reg) - CNT_W'(1)))
        else $error("shift did not move the insert position up");

endmodule

FILE: hdl/dedup_sorted_cell_list.sv
// Top level of the sorted, deduplicated cell list.
// Instantiates dscl_ctrl and dscl_datapath; types and constants from dscl_pkg.
//
//  Channel   Handshake             Beat contents
//  --------  --------------------  -----------------------------------------------
//  request   req_valid/req_ready   req_type, channel_number, carrier_hz,
//                                  cell_identity, strength, margin, row
//  response  rsp_valid/rsp_ready   status, entry_count, insert_row, out_channel,
//                                  out_hz, out_identity, out_strength, out_margin
//
// From an accepted request beat to its response beat: a clear or a read goes
// from dispatch straight to the response; an insert scans the stored rows and
// stops at a duplicate, reports a full list after the whole scan, and else
// moves each weaker entry down one row before it writes the new entry.
// The entry memory has a registered read, so each check or move is a read
// followed by a compare or write.
// Only one request is in flight; req_ready is high in the idle state only.
// A stalled response is held in the result register, and the controller waits
// with the next result until that beat is taken.
// Reset empties the list at once (fill count to zero); the memory is not swept.
module dedup_sorted_cell_list
    import dscl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [1:0]         req_type,
    input  logic [17:0]        channel_number,
    input  logic [31:0]        carrier_hz,
    input  logic [8:0]         cell_identity,
    input  logic [15:0]        strength,
    input  logic signed [15:0] margin,
    input  logic [3:0]         row,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic [2:0]         status,
    output logic [4:0]         entry_count,
    output logic [3:0]         insert_row,
    output logic [17:0]        out_channel,
    output logic [31:0]        out_hz,
    output logic [8:0]         out_identity,
    output logic [15:0]        out_strength,
    output logic signed [15:0] out_margin
);

    // The controller sequences each request; the datapath owns the entry memory and the request and result registers.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    dscl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath latches the request beat when the controller accepts it,
    // scans the stored identities, shifts weaker entries down and builds the
    // response beat in its result register.
    dscl_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .channel_number (channel_number),
        .carrier_hz     (carrier_hz),
        .cell_identity  (cell_identity),
        .strength       (strength),
        .margin         (margin),
        .row            (row),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .entry_count    (entry_count),
        .insert_row     (insert_row),
        .out_channel    (out_channel),
        .out_hz         (out_hz),
        .out_identity   (out_identity),
        .out_strength   (out_strength),
        .out_margin     (out_margin)
    );

endmodule
